FILE: rtl/core/rrf_pkg.sv
// Shared types and codes for the rectangle region finder.
package rrf_pkg;

   typedef logic [1:0] cell_type;

   localparam cell_type CELL_EMPTY   = 2'd0;
   localparam cell_type CELL_REGION  = 2'd1;
   localparam cell_type CELL_VISITED = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_FIND = 1'b1;

   localparam int unsigned REG_NUM_ROWS = 0;
   localparam int unsigned REG_NUM_COLS = 1;

   typedef struct packed {
      logic       opcode;
      logic [5:0] row_addr;
      logic [5:0] col_addr;
      logic       pixel;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [11:0] region_number;
      logic [5:0]  top_row;
      logic [5:0]  left_col;
      logic [6:0]  width;
      logic [6:0]  height;
      logic [12:0] area;
   } rsp_type;

endpackage

FILE: rtl/core/rrf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rrf_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/rectangle_region_finder_top.sv
// Top level of the rectangle region finder: sequencer, scan counters and CSRs.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ---------------------------------
//   request   start, busy, req_data          taken when start is high, busy low
//   response  rsp_strobe, rsp_data           one-cycle strobe, no back-pressure
//   config    psel, penable, pwrite, paddr,  APB write in the access cycle,
//             pwdata, prdata, pready         pready always high
//
// A load transaction writes one cell. A find transaction walks the cell RAM one
// cell per cycle through its single registered read port: it starts at the saved
// scan position, scans cells until one holds a region, rereads the corner, marks
// the region's cells row by row, and forms the area. The response strobe rises in
// the same cycle that busy falls, or in the cycle after start for a find that is
// answered from idle. Reset is synchronous, clears the scan position and region
// count, and sets both size registers to 64; the cell RAM is not cleared.
module rectangle_region_finder_top #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rrf_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rrf_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   import rrf_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RI    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CI    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = RW + CW;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MARK,
      S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [RW-1:0]    pos_row_ff, pos_row_in;
   logic [CW-1:0]    pos_col_ff, pos_col_in;
   logic [RW-1:0]    top_ff, top_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [CW-1:0]    w_ff, w_in;
   logic [RW-1:0]    h_ff, h_in;
   logic [RI-1:0]    scan_row_ff, scan_row_in;
   logic [CI-1:0]    scan_col_ff, scan_col_in;
   logic             scan_done_ff, scan_done_in;
   logic [11:0]      count_ff, count_in;
   rsp_type          rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;
   logic [6:0]       num_rows_ff, num_cols_ff;

   logic [RW-1:0]    rows_used;
   logic [CW-1:0]    cols_used;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   cell_type         ram_wdata;
   logic [RW-1:0]    rd_row;
   logic [CW-1:0]    rd_col;
   cell_type         ram_rdata;
   logic [RW-1:0]    r0, nr, row_next;
   logic [CW-1:0]    c0, nc, col_next, c_end;
   logic             row_end;
   logic [PW-1:0]    prod;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
      return AW'(32'(r) * MAX_COLS + 32'(c));
   endfunction

   assign rows_used = (32'(num_rows_ff) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(num_rows_ff);
   assign cols_used = (32'(num_cols_ff) > MAX_COLS) ? CW'(MAX_COLS) : CW'(num_cols_ff);

   assign row_next = RW'(pos_row_ff + 1'b1);
   assign col_next = CW'(pos_col_ff + 1'b1);
   assign prod     = PW'(w_ff) * PW'(h_ff);

   rrf_ram #(
      .WIDTH ($bits(cell_type)),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cell_addr(rd_row, rd_col)),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      pos_row_in   = pos_row_ff;
      pos_col_in   = pos_col_ff;
      top_in       = top_ff;
      left_in      = left_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      scan_row_in  = scan_row_ff;
      scan_col_in  = scan_col_ff;
      scan_done_in = scan_done_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      strobe_in    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = cell_addr(pos_row_ff, pos_col_ff);
      ram_wdata    = CELL_VISITED;
      rd_row       = pos_row_ff;
      rd_col       = pos_col_ff;
      r0           = RW'(scan_row_ff);
      c0           = CW'(scan_col_ff);
      nr           = pos_row_ff;
      nc           = col_next;
      c_end        = pos_col_ff;
      row_end      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.opcode == OP_LOAD) begin
                  if (32'(req_data.row_addr) < MAX_ROWS &&
                      32'(req_data.col_addr) < MAX_COLS) begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(32'(req_data.row_addr) * MAX_COLS +
                                     32'(req_data.col_addr));
                     ram_wdata = {1'b0, req_data.pixel};
                  end
               end else if (scan_done_ff) begin
                  rsp_in    = '0;
                  strobe_in = 1'b1;
               end else begin
                  // A saved column beyond the columns in use wraps to the next row.
                  if (c0 >= cols_used) begin
                     r0 = RW'(r0 + 1'b1);
                     c0 = '0;
                  end
                  if (r0 < rows_used && cols_used != '0) begin
                     rd_row     = r0;
                     rd_col     = c0;
                     pos_row_in = r0;
                     pos_col_in = c0;
                     state_in   = S_SCAN;
                  end else begin
                     scan_done_in = 1'b1;
                     rsp_in       = '0;
                     strobe_in    = 1'b1;
                  end
               end
            end
         end

         S_SCAN: begin
            if (ram_rdata == CELL_REGION) begin
               top_in   = pos_row_ff;
               left_in  = pos_col_ff;
               w_in     = '0;
               h_in     = '0;
               count_in = 12'(count_ff + 1'b1);
               if (col_next < cols_used) begin
                  scan_row_in = RI'(pos_row_ff);
                  scan_col_in = CI'(col_next);
               end else if (row_next < rows_used) begin
                  scan_row_in = RI'(row_next);
                  scan_col_in = '0;
               end else begin
                  scan_done_in = 1'b1;
               end
               // Reread the corner so the marking walk starts with its data.
               state_in = S_MARK;
            end else begin
               if (col_next >= cols_used) begin
                  nc = '0;
                  nr = row_next;
               end
               if (nr < rows_used) begin
                  rd_row     = nr;
                  rd_col     = nc;
                  pos_row_in = nr;
                  pos_col_in = nc;
               end else begin
                  scan_done_in = 1'b1;
                  rsp_in       = '0;
                  strobe_in    = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end

         S_MARK: begin
            if (ram_rdata == CELL_REGION) begin
               ram_we = 1'b1;
               if (col_next < cols_used) begin
                  rd_col     = col_next;
                  pos_col_in = col_next;
               end else begin
                  row_end = 1'b1;
                  c_end   = col_next;
               end
            end else if (pos_col_ff == left_ff) begin
               // The corner column has ended, so the height is final.
               state_in = S_FINISH;
            end else begin
               row_end = 1'b1;
               c_end   = pos_col_ff;
            end
            if (row_end) begin
               w_in = CW'(c_end - left_ff);
               h_in = RW'(h_ff + 1'b1);
               if (row_next < rows_used) begin
                  rd_row     = row_next;
                  rd_col     = left_ff;
                  pos_row_in = row_next;
                  pos_col_in = left_ff;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            rsp_in.found         = 1'b1;
            rsp_in.region_number = count_ff;
            rsp_in.top_row       = 6'(top_ff);
            rsp_in.left_col      = 6'(left_ff);
            rsp_in.width         = 7'(w_ff);
            rsp_in.height        = 7'(h_ff);
            rsp_in.area          = 13'(prod);
            strobe_in            = 1'b1;
            state_in             = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_row_ff  <= '0;
         scan_col_ff  <= '0;
         scan_done_ff <= 1'b0;
         count_ff     <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_row_ff  <= scan_row_in;
         scan_col_ff  <= scan_col_in;
         scan_done_ff <= scan_done_in;
         count_ff     <= count_in;
         strobe_ff    <= strobe_in;
      end
      pos_row_ff <= pos_row_in;
      pos_col_ff <= pos_col_in;
      top_ff     <= top_in;
      left_ff    <= left_in;
      w_ff       <= w_in;
      h_ff       <= h_in;
      rsp_ff     <= rsp_in;
   end

   // Configuration registers; the word address alone selects the register.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= 7'd64;
         num_cols_ff <= 7'd64;
      end else if (psel && penable && pwrite) begin
         if (32'(paddr[2]) == REG_NUM_ROWS) begin
            num_rows_ff <= pwdata[6:0];
         end else begin
            num_cols_ff <= pwdata[6:0];
         end
      end
   end

   assign prdata     = (32'(paddr[2]) == REG_NUM_ROWS) ? {25'd0, num_rows_ff}
                                                       : {25'd0, num_cols_ff};
   assign pready     = 1'b1;
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: tb/tb_rectangle_region_finder_top.sv
// Self-checking testbench for the rectangle region finder top level.
module tb_rectangle_region_finder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rrf_pkg::*;

   localparam int unsigned MAX_ROWS = 64;
   localparam int unsigned MAX_COLS = 64;
   localparam int unsigned QUIET_LIMIT = 40000;

   typedef enum logic [1:0] {STEP_LOAD, STEP_FIND, STEP_CSR} step_kind_e;

   typedef struct packed {
      step_kind_e  kind;
      int unsigned a;      // row, or register index
      int unsigned b;      // column, or register value
      bit          pixel;
      bit          typed;
      rsp_type     want;
   } script_row_t;

   localparam rsp_type NOT_FOUND = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   rectangle_region_finder_top #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #1 clock = ~clock;

   // Mirror of the block: image, scan position, region count and registers.
   cell_type    image [MAX_ROWS][MAX_COLS];
   logic [5:0]  scan_row = '0;
   logic [5:0]  scan_col = '0;
   bit          scan_done = 1'b0;
   logic [11:0] region_total = '0;
   logic [6:0]  rows_reg = 7'd64;
   logic [6:0]  cols_reg = 7'd64;

   rsp_type     pending_regions [$];
   int unsigned sender_idle_pct = 0;
   int unsigned n_loads = 0;
   int unsigned n_finds = 0;
   int unsigned n_regions = 0;
   int unsigned n_csr = 0;
   int unsigned n_checked = 0;
   int unsigned n_mismatch = 0;

   script_row_t opening_script [20] = '{
      '{STEP_LOAD, 0, 0, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_LOAD, 0, 1, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_LOAD, 1, 0, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_LOAD, 1, 1, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_LOAD, 1, 2, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_FIND, 0, 0, 1'b0, 1'b1, '{1'b1, 12'd1, 6'd0, 6'd0, 7'd3, 7'd2, 13'd6}},
      // Reload a visited cell that still lies ahead of the scan.
      '{STEP_LOAD, 1, 2, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_FIND, 0, 0, 1'b0, 1'b1, '{1'b1, 12'd2, 6'd1, 6'd2, 7'd1, 7'd1, 13'd1}},
      '{STEP_LOAD, 2, 63, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_LOAD, 3, 63, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_CSR, REG_NUM_COLS, 100, 1'b0, 1'b0, NOT_FOUND},
      '{STEP_FIND, 0, 0, 1'b0, 1'b1, '{1'b1, 12'd3, 6'd2, 6'd63, 7'd1, 7'd2, 13'd2}},
      '{STEP_CSR, REG_NUM_COLS, 40, 1'b0, 1'b0, NOT_FOUND},
      '{STEP_LOAD, 3, 38, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_LOAD, 3, 39, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_LOAD, 3, 40, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_FIND, 0, 0, 1'b0, 1'b1, '{1'b1, 12'd4, 6'd3, 6'd38, 7'd2, 7'd1, 13'd2}},
      '{STEP_CSR, REG_NUM_ROWS, 127, 1'b0, 1'b0, NOT_FOUND},
      '{STEP_CSR, REG_NUM_COLS, 64, 1'b0, 1'b0, NOT_FOUND},
      '{STEP_FIND, 0, 0, 1'b0, 1'b1, '{1'b1, 12'd5, 6'd3, 6'd40, 7'd1, 7'd1, 13'd1}}
   };

   // The scan sits at row 3 or later here, so every query ends it or finds it ended.
   script_row_t closing_script [8] = '{
      '{STEP_CSR, REG_NUM_ROWS, 0, 1'b0, 1'b0, NOT_FOUND},
      '{STEP_FIND, 0, 0, 1'b0, 1'b1, NOT_FOUND},
      '{STEP_CSR, REG_NUM_ROWS, 64, 1'b0, 1'b0, NOT_FOUND},
      '{STEP_LOAD, 63, 0, 1'b1, 1'b0, NOT_FOUND},
      '{STEP_FIND, 0, 0, 1'b0, 1'b1, NOT_FOUND},
      '{STEP_CSR, REG_NUM_COLS, 1, 1'b0, 1'b0, NOT_FOUND},
      '{STEP_CSR, REG_NUM_ROWS, 1, 1'b0, 1'b0, NOT_FOUND},
      '{STEP_FIND, 0, 0, 1'b0, 1'b1, NOT_FOUND}
   };

   function automatic int unsigned used_rows();
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
   endfunction

   function automatic int unsigned used_cols();
      return (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
   endfunction

   // Applies one transaction to the mirror; returns 1 when it yields a result.
   function automatic bit next_region(input req_type item, output rsp_type region);
      int unsigned rows, cols, r, c, top, left, w, h;
      bit hit;
      rows = used_rows();
      cols = used_cols();
      region = '0;
      if (item.opcode == OP_LOAD) begin
         image[item.row_addr][item.col_addr] = item.pixel ? CELL_REGION : CELL_EMPTY;
         return 1'b0;
      end
      hit = 1'b0;
      top = 0;
      left = 0;
      if (!scan_done) begin
         r = scan_row;
         c = scan_col;
         while (r < rows && !hit) begin
            if (c >= cols) begin
               c = 0;
               r++;
            end else if (image[r][c] == CELL_REGION) begin
               hit = 1'b1;
               top = r;
               left = c;
            end else begin
               c++;
            end
         end
         if (!hit) begin
            scan_done = 1'b1;
         end else if (left + 1 < cols) begin
            scan_row = 6'(top);
            scan_col = 6'(left + 1);
         end else if (top + 1 < rows) begin
            scan_row = 6'(top + 1);
            scan_col = '0;
         end else begin
            scan_done = 1'b1;
         end
      end
      if (!hit) return 1'b1;
      region_total++;
      w = 0;
      h = 0;
      r = top;
      // Width is the run in the last row counted, not the widest row.
      while (r < rows && image[r][left] == CELL_REGION) begin
         c = left;
         while (c < cols && image[r][c] == CELL_REGION) begin
            image[r][c] = CELL_VISITED;
            c++;
         end
         w = c - left;
         h++;
         r++;
      end
      region.found = 1'b1;
      region.region_number = region_total;
      region.top_row = 6'(top);
      region.left_col = 6'(left);
      region.width = 7'(w);
      region.height = 7'(h);
      region.area = 13'(w * h);
      return 1'b1;
   endfunction

   function automatic string show_region(input rsp_type region);
      return $sformatf("found=%0b region=%0d corner=(%0d,%0d) size=%0dx%0d area=%0d",
                       region.found, region.region_number, region.top_row,
                       region.left_col, region.width, region.height, region.area);
   endfunction

   function automatic void note_mismatch(input string what, input string want,
                                         input string got);
      n_mismatch++;
      if (n_mismatch <= 10) begin
         $display("mismatch, %s: expected %s, got %s", what, want, got);
      end
   endfunction

   function automatic req_type load_item(input int unsigned r, input int unsigned c,
                                         input bit px);
      req_type item;
      item.opcode = OP_LOAD;
      item.row_addr = 6'(r);
      item.col_addr = 6'(c);
      item.pixel = px;
      return item;
   endfunction

   function automatic req_type find_item();
      req_type item;
      item = req_type'($urandom);
      item.opcode = OP_FIND;
      return item;
   endfunction

   task automatic issue(input req_type item, input bit typed = 1'b0,
                        input rsp_type want = '0);
      rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if (next_region(item, predicted)) begin
         pending_regions.push_back(typed ? want : predicted);
         n_finds++;
         if (predicted.found) n_regions++;
      end else begin
         n_loads++;
      end
   endtask

   task automatic drain(input int unsigned tail);
      start <= 1'b0;
      while (pending_regions.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic csr_check(input int unsigned idx);
      logic [31:0] want;
      want = {25'd0, (idx == REG_NUM_ROWS) ? rows_reg : cols_reg};
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= 3'(idx << 2);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         note_mismatch($sformatf("register %0d readback", idx),
                       $sformatf("%0d", want), $sformatf("%0d", prdata));
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_write(input int unsigned idx, input logic [31:0] value);
      drain(8);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(idx << 2);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_NUM_ROWS) rows_reg = value[6:0];
      else if (idx == REG_NUM_COLS) cols_reg = value[6:0];
      n_csr++;
      csr_check(idx);
   endtask

   task automatic run_step(input script_row_t step);
      case (step.kind)
         STEP_LOAD: issue(load_item(step.a, step.b, step.pixel));
         STEP_FIND: issue(find_item(), step.typed, step.want);
         default: csr_write(step.a, step.b);
      endcase
   endtask

   // Moves the image size while the scan is under way, keeping enough rows ahead of it.
   task automatic pick_setting();
      int unsigned floor_rows, rows_val, cols_val;
      logic [31:0] junk;
      floor_rows = (scan_row + 8 > MAX_ROWS) ? MAX_ROWS : scan_row + 8;
      if ($urandom_range(3) == 0) rows_val = $urandom_range(65, 127);
      else rows_val = $urandom_range(floor_rows, MAX_ROWS);
      case ($urandom_range(4))
         0: cols_val = MAX_COLS;
         1: cols_val = 1;
         2: cols_val = $urandom_range(65, 127);
         default: cols_val = $urandom_range(2, 63);
      endcase
      junk = ($urandom_range(3) == 0) ? ($urandom & 32'hFFFF_FF80) : 32'd0;
      csr_write(REG_NUM_ROWS, rows_val | junk);
      csr_write(REG_NUM_COLS, cols_val);
   endtask

   // Draws a small, possibly ragged rectangle just ahead of the scan, then queries.
   task automatic plant_and_find(output int unsigned count);
      int unsigned rows, cols, r, c, w, h, i, j;
      count = 0;
      rows = used_rows();
      cols = used_cols();
      r = scan_row;
      c = scan_col;
      if (cols != 0) begin
         if (c >= cols) begin
            r++;
            c = 0;
         end
         c += $urandom_range(0, (cols < 10) ? 2 * cols : 20);
         r += c / cols;
         c = c % cols;
      end
      if (!scan_done && cols != 0 && r < rows) begin
         w = $urandom_range(1, 4);
         h = $urandom_range(1, 3);
         for (i = 0; i < h; i++) begin
            for (j = 0; j < w; j++) begin
               if (r + i < MAX_ROWS && c + j < MAX_COLS) begin
                  issue(load_item(r + i, c + j,
                                  (i == 0 && j == 0) || ($urandom_range(99) < 88)));
                  count++;
               end
            end
         end
      end
      issue(find_item());
      count++;
   endtask

   task automatic run_random_phase(input int unsigned idle_pct, input int unsigned quota);
      int unsigned issued, pick, count, k;
      sender_idle_pct = idle_pct;
      pick_setting();
      issued = 0;
      while (issued < quota) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            plant_and_find(count);
            issued += count;
         end else if (pick < 90) begin
            count = $urandom_range(1, 3);
            for (k = 0; k < count; k++) begin
               issue(load_item($urandom_range(63), $urandom_range(63),
                               $urandom_range(99) < 25));
            end
            issued += count;
            if ($urandom_range(1) == 1) begin
               issue(find_item());
               issued++;
            end
         end else begin
            issue(find_item());
            issued++;
         end
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_regions.size() == 0) begin
            note_mismatch("result with no query outstanding", "nothing",
                          show_region(rsp_data));
         end else begin
            want = pending_regions.pop_front();
            n_checked++;
            if (rsp_data.found !== want.found ||
                rsp_data.region_number !== want.region_number ||
                rsp_data.top_row !== want.top_row ||
                rsp_data.left_col !== want.left_col ||
                rsp_data.width !== want.width ||
                rsp_data.height !== want.height ||
                rsp_data.area !== want.area) begin
               note_mismatch("find result", show_region(want), show_region(rsp_data));
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe || (psel && penable)) quiet = 0;
         else quiet++;
      end
      $display("FAIL rectangle_region_finder_top");
      $finish;
   end

   initial begin : stimulus
      int unsigned r, c;
      foreach (image[i, j]) image[i][j] = CELL_EMPTY;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(REG_NUM_ROWS);
      csr_check(REG_NUM_COLS);

      // The cell RAM comes up undefined, so clear every cell before any query.
      sender_idle_pct = 0;
      for (r = 0; r < MAX_ROWS; r++) begin
         for (c = 0; c < MAX_COLS; c++) begin
            issue(load_item(r, c, 1'b0));
         end
      end

      sender_idle_pct = 13;
      foreach (opening_script[i]) run_step(opening_script[i]);

      run_random_phase(0, 28);
      run_random_phase(57, 28);
      run_random_phase(0, 28);
      run_random_phase(13, 28);

      sender_idle_pct = 0;
      foreach (closing_script[i]) run_step(closing_script[i]);

      drain(20);
      $display("Ran %0d cell loads and %0d find queries (%0d regions found) over %0d register writes.",
               n_loads, n_finds, n_regions, n_csr);
      $display("Checked %0d find results; %0d mismatches.", n_checked, n_mismatch);
      if (n_mismatch == 0 && pending_regions.size() == 0) begin
         $display("PASS rectangle_region_finder_top");
      end else begin
         $display("FAIL rectangle_region_finder_top");
      end
      $finish;
   end

endmodule
